FILE: rtl/mbs_pkg.sv
// shared types, codes and functions for the modbus master command sequencer
package mbs_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int MAX_FRAME_DEF   = 256;

  localparam int CMD_W   = 3;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 1;

  // input modes
  localparam logic [1:0] MODE_ENQ  = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_BYTE = 2'd2;

  // event kinds
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_ISSUED  = 3'd1;
  localparam logic [2:0] EV_ACCEPT  = 3'd2;
  localparam logic [2:0] EV_REJECT  = 3'd3;
  localparam logic [2:0] EV_TIMEOUT = 3'd4;

  // ui status codes
  localparam logic [1:0] UI_NONE    = 2'd0;
  localparam logic [1:0] UI_SENDING = 2'd1;
  localparam logic [1:0] UI_DONE    = 2'd2;
  localparam logic [1:0] UI_FAIL    = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLAVE   = 1'd1;

  // frame constants
  localparam logic [7:0]  FC_READ    = 8'h03;
  localparam logic [7:0]  FC_WRITE   = 8'h10;
  localparam logic [CMD_W-1:0] LAST_READ_CMD = 3'd2;
  localparam int          MIN_FRAME  = 5;
  localparam int          HEAD_LEN   = 3;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [15:0] WAIT_MAX   = 16'hFFFF;
  localparam logic [15:0] TIMEOUT_RST = 16'd1000;
  localparam logic [7:0]  SLAVE_RST  = 8'd1;

  typedef struct packed {
    logic [1:0]       mode;
    logic [CMD_W-1:0] cmd_code;
    logic [7:0]       rx_byte;
    logic             rx_last;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       event_kind;
    logic [CMD_W-1:0] event_cmd;
    logic [1:0]       ui_status;
    logic             enqueue_dropped;
    logic [3:0]       queue_level;
  } out_item_t;

  // queue control from the sequencer
  typedef struct packed {
    logic             push;
    logic             pop;
    logic [CMD_W-1:0] cmd;
  } q_ctl_t;

  // queue status back to the sequencer
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // bytewise modbus crc-16, reflected
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // byte count expected in a read response
  function automatic logic [7:0] read_byte_count(input logic [CMD_W-1:0] cmd);
    logic [7:0] n;
    case (cmd)
      3'd0:    n = 8'd12;
      3'd1:    n = 8'd8;
      default: n = 8'd2;
    endcase
    return n;
  endfunction

endpackage

FILE: rtl/mbs_cmd_queue.sv
// ring queue of pending command codes with a registered head read
module mbs_cmd_queue #(
  parameter int QUEUE_DEPTH = mbs_pkg::QUEUE_DEPTH_DEF,
  parameter int LVL_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mbs_pkg::q_ctl_t              ctl,
  output mbs_pkg::q_stat_t             stat,
  output logic [mbs_pkg::CMD_W-1:0]    head_cmd,
  output logic [LVL_W-1:0]             fill_level
);
  import mbs_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic [CMD_W-1:0] mem [QUEUE_DEPTH];
  logic [CMD_W-1:0] head_r;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [LVL_W-1:0] fill_r, fill_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    fill_nxt   = fill_r;
    if (ctl.push) begin
      wr_ptr_nxt = ptr_inc(wr_ptr_r);
      fill_nxt   = fill_r + 1'b1;
    end else if (ctl.pop) begin
      rd_ptr_nxt = ptr_inc(rd_ptr_r);
      fill_nxt   = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // head register follows the next read pointer, with write bypass
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_ptr_r] <= ctl.cmd;
    end
    if (ctl.push && (wr_ptr_r == rd_ptr_nxt)) begin
      head_r <= ctl.cmd;
    end else begin
      head_r <= mem[rd_ptr_nxt];
    end
  end

  assign head_cmd   = head_r;
  assign fill_level = fill_r;
  assign stat.full  = (fill_r == LVL_W'(QUEUE_DEPTH));
  assign stat.empty = (fill_r == '0);

endmodule

FILE: rtl/modbus_master_command_sequencer.sv
// top level of the modbus master command sequencer
// One item is taken per clock while the result register is free or draining.
// Each item goes through an input register and then the logic that updates
// the queue, the command state and the receive crc, landing in the result
// register, for a sustained rate of one item per cycle while out_ready holds.
// That rate is set by the state update, where the bytewise crc-16 and the
// queue pointer step both sit. The command queue is a small memory with a
// registered head read; it needs no clearing pass after reset. Every item
// yields exactly one result item; event_kind none marks items that caused
// nothing. The input stage keeps accepting while a result waits, as long as
// the result register can drain in the same cycle.
module modbus_master_command_sequencer #(
  parameter int QUEUE_DEPTH = mbs_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_FRAME   = mbs_pkg::MAX_FRAME_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  mbs_pkg::in_item_t                 in_data,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output mbs_pkg::out_item_t                out_data,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [mbs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mbs_pkg::CFG_W-1:0]         cfg_wdata
);
  import mbs_pkg::*;

  localparam int LVL_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int FLEN_W = $clog2(MAX_FRAME + 2);

  // config registers
  logic [15:0] timeout_r;
  logic [7:0]  slave_r;

  // input stage
  logic        s1_valid_r;
  in_item_t    s1_item_r;
  logic        advance;

  // result register
  logic        out_valid_r;
  out_item_t   out_data_r;
  out_item_t   res;

  // command and receive state
  logic              busy_r, busy_nxt;
  logic [CMD_W-1:0]  active_r, active_nxt;
  logic [15:0]       wait_r, wait_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic [FLEN_W-1:0] flen_r, flen_nxt;
  logic [7:0]        head_r [HEAD_LEN];
  logic [7:0]        head_nxt [HEAD_LEN];

  // queue link
  q_ctl_t            q_ctl;
  q_stat_t           q_stat;
  logic [CMD_W-1:0]  q_head;
  logic [LVL_W-1:0]  q_fill;
  logic [LVL_W-1:0]  lvl_after;

  logic [15:0]       wait_inc;
  logic              frame_ok;
  logic              is_write;

  mbs_cmd_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .LVL_W       (LVL_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (q_ctl),
    .stat       (q_stat),
    .head_cmd   (q_head),
    .fill_level (q_fill)
  );

  // handshake: the stage moves when the result register is free or draining
  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
      slave_r   <= SLAVE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIMEOUT: timeout_r <= cfg_wdata;
        REG_SLAVE:   slave_r   <= cfg_wdata[7:0];
        default:     ;
      endcase
    end
  end

  // item processing
  always_comb begin
    busy_nxt   = busy_r;
    active_nxt = active_r;
    wait_nxt   = wait_r;
    crc_nxt    = crc_r;
    flen_nxt   = flen_r;
    for (int i = 0; i < HEAD_LEN; i++) begin
      head_nxt[i] = head_r[i];
    end
    q_ctl.push = 1'b0;
    q_ctl.pop  = 1'b0;
    q_ctl.cmd  = s1_item_r.cmd_code;
    res        = '0;
    wait_inc   = (wait_r != WAIT_MAX) ? wait_r + 16'd1 : wait_r;
    frame_ok   = 1'b0;
    is_write   = (active_r > LAST_READ_CMD);

    case (s1_item_r.mode)
      MODE_ENQ: begin
        if (q_stat.full) begin
          res.enqueue_dropped = 1'b1;
        end else begin
          q_ctl.push = 1'b1;
        end
      end
      MODE_TICK: begin
        if (busy_r) begin
          wait_nxt = wait_inc;
          if (wait_inc >= timeout_r) begin
            // response never came
            busy_nxt       = 1'b0;
            crc_nxt        = CRC_INIT;
            flen_nxt       = '0;
            for (int i = 0; i < HEAD_LEN; i++) begin
              head_nxt[i] = '0;
            end
            res.event_kind = EV_TIMEOUT;
            res.event_cmd  = active_r;
            res.ui_status  = is_write ? UI_FAIL : UI_NONE;
          end
        end else if (!q_stat.empty) begin
          // issue the oldest queued command
          q_ctl.pop      = 1'b1;
          active_nxt     = q_head;
          busy_nxt       = 1'b1;
          wait_nxt       = '0;
          crc_nxt        = CRC_INIT;
          flen_nxt       = '0;
          for (int i = 0; i < HEAD_LEN; i++) begin
            head_nxt[i] = '0;
          end
          res.event_kind = EV_ISSUED;
          res.event_cmd  = q_head;
          res.ui_status  = (q_head > LAST_READ_CMD) ? UI_SENDING : UI_NONE;
        end
      end
      MODE_BYTE: begin
        if (busy_r) begin
          if (flen_r < FLEN_W'(MAX_FRAME)) begin
            crc_nxt = crc16_byte(crc_r, s1_item_r.rx_byte);
            if (flen_r < FLEN_W'(HEAD_LEN)) begin
              head_nxt[flen_r[1:0]] = s1_item_r.rx_byte;
            end
            flen_nxt = flen_r + 1'b1;
          end else begin
            // overlong frame, held past the limit so it fails the check
            flen_nxt = FLEN_W'(MAX_FRAME + 1);
          end
          if (s1_item_r.rx_last) begin
            frame_ok = (flen_nxt >= FLEN_W'(MIN_FRAME)) &&
                       (flen_nxt <= FLEN_W'(MAX_FRAME)) &&
                       (crc_nxt == 16'h0000) &&
                       (head_nxt[0] == slave_r) &&
                       (is_write ? (head_nxt[1] == FC_WRITE)
                                 : ((head_nxt[1] == FC_READ) &&
                                    (head_nxt[2] == read_byte_count(active_r))));
            res.event_kind = frame_ok ? EV_ACCEPT : EV_REJECT;
            res.event_cmd  = active_r;
            res.ui_status  = is_write ? (frame_ok ? UI_DONE : UI_FAIL) : UI_NONE;
            busy_nxt       = 1'b0;
            crc_nxt        = CRC_INIT;
            flen_nxt       = '0;
            for (int i = 0; i < HEAD_LEN; i++) begin
              head_nxt[i] = '0;
            end
          end
        end
      end
      default: ;
    endcase

    // queue hold-back only moves when the stage advances
    q_ctl.push = q_ctl.push && advance;
    q_ctl.pop  = q_ctl.pop && advance;

    // level after this item
    if (q_ctl.push) begin
      lvl_after = q_fill + 1'b1;
    end else if (q_ctl.pop) begin
      lvl_after = q_fill - 1'b1;
    end else begin
      lvl_after = q_fill;
    end
    res.queue_level = 4'(lvl_after);
  end

  // input stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res;
    end
  end

  // command and receive state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      active_r <= '0;
      wait_r   <= '0;
      crc_r    <= CRC_INIT;
      flen_r   <= '0;
      for (int i = 0; i < HEAD_LEN; i++) begin
        head_r[i] <= '0;
      end
    end else if (advance) begin
      busy_r   <= busy_nxt;
      active_r <= active_nxt;
      wait_r   <= wait_nxt;
      crc_r    <= crc_nxt;
      flen_r   <= flen_nxt;
      for (int i = 0; i < HEAD_LEN; i++) begin
        head_r[i] <= head_nxt[i];
      end
    end
  end

endmodule

FILE: rtl/mbs_checker.sv
// port-level checker for the modbus master command sequencer, with its bind
module mbs_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  mbs_pkg::out_item_t                out_data
);
  import mbs_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // an empty event carries no command or status
  a_none_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_kind == EV_NONE) |->
      (out_data.event_cmd == '0) && (out_data.ui_status == UI_NONE))
    else $error("empty event carries command or status");

  // read commands never report a ui status
  a_read_no_ui: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_cmd <= LAST_READ_CMD) |->
      (out_data.ui_status == UI_NONE))
    else $error("read command reported a ui status");

  // a dropped enqueue causes no event
  a_drop_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.enqueue_dropped |-> (out_data.event_kind == EV_NONE))
    else $error("dropped enqueue with an event");

  // no result comes out of reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind modbus_master_command_sequencer mbs_checker u_mbs_checker (.*);
